// ===== rtl/sise_pkg.sv =====
// Package for the SPARC integer subset execute block.
// Holds widths, opcode codes, reset constants and the execute result type.
// No dependencies; imported by every module of the block.
package sise_pkg;

  localparam int unsigned XLen     = 64;
  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned InstrW   = 32;

  // configuration register indexes
  localparam logic CfgStartAddr  = 1'b0;
  localparam logic CfgNarrowMode = 1'b1;

  localparam logic [XLen-1:0] StartAddrReset = '0;
  localparam logic [XLen-1:0] PcStep         = 64'd4;

  // op field
  localparam logic [1:0] OpFmt2  = 2'd0;
  localparam logic [1:0] OpCall  = 2'd1;
  localparam logic [1:0] OpArith = 2'd2;

  // op2 field of format 2
  localparam logic [2:0] Op2Bicc  = 3'd2;
  localparam logic [2:0] Op2Sethi = 3'd4;

  // rd field of a branch: cond = always, annul clear
  localparam logic [4:0] BranchAlways = 5'h08;

  // op3 field of format 3
  localparam logic [5:0] Op3Add  = 6'd0;
  localparam logic [5:0] Op3And  = 6'd1;
  localparam logic [5:0] Op3Or   = 6'd2;
  localparam logic [5:0] Op3Xor  = 6'd3;
  localparam logic [5:0] Op3Sub  = 6'd4;
  localparam logic [5:0] Op3Sll  = 6'd37;
  localparam logic [5:0] Op3Srl  = 6'd38;
  localparam logic [5:0] Op3Sra  = 6'd39;
  localparam logic [5:0] Op3Jmpl = 6'd56;

  localparam logic [RegIdxW-1:0] LinkReg = 5'd15;

  typedef struct packed {
    logic               illegal;
    logic               wr;
    logic [RegIdxW-1:0] widx;
    logic [XLen-1:0]    wval;
    logic [XLen-1:0]    npc_new;
  } exec_res_t;

endpackage

// ===== rtl/sparc_integer_subset_execute.sv =====
// Top level of the SPARC integer subset execute block.
// Depends on sise_pkg, sise_ram (register file) and sise_alu (execute logic).
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+----------------------------------------
//  instr in  | in_valid_i / in_ready_o        | instr_word_i[31:0]
//  result    | out_valid_o / out_ready_i      | executed_address_o, next_fetch_o,
//            |                                | dest_index_o, dest_value_o,
//            |                                | dest_written_o, illegal_o
//  config    | cfg_we_i (no wait)             | cfg_index_i, cfg_wdata_i[63:0]
//
// One instruction per cycle sustained while out_ready_i keeps up. First the word
// is captured into the execute stage while the register file (registered-read RAM)
// is read at rs1/rs2; then execute, write back and load the result register.
// A write from the previous instruction is forwarded, since it lands on the read edge.
// Reset clears pc/npc, the per-register valid bits (file reads as zero) and all
// handshake state; no clearing pass. A stalled result holds the execute stage,
// which in turn holds in_ready_o low only when both stages are occupied.
module sparc_integer_subset_execute
  import sise_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // instruction channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InstrW-1:0]  instr_word_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [XLen-1:0]    executed_address_o,
  output logic [XLen-1:0]    next_fetch_o,
  output logic [RegIdxW-1:0] dest_index_o,
  output logic [XLen-1:0]    dest_value_o,
  output logic               dest_written_o,
  output logic               illegal_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [XLen-1:0]    cfg_wdata_i
);

  // config: writes to the start address index are ignored and pc resets to
  // StartAddrReset; narrow mode gates the x shifts
  logic narrow_q;

  // execute stage
  logic              ex_vld_q;
  logic [InstrW-1:0] instr_q;
  logic              vld_a_q, vld_b_q;
  logic [XLen-1:0]   rdata_a, rdata_b;

  // architectural pc/npc
  logic [XLen-1:0] pc_q, npc_q;

  // register file support
  logic [NumRegs-1:0] rvld_q;      // entry written since reset
  logic               fwd_vld_q;
  logic [RegIdxW-1:0] fwd_idx_q;
  logic [XLen-1:0]    fwd_val_q;

  // result register
  logic               out_vld_q;
  logic [XLen-1:0]    exec_addr_q, next_fetch_q, dest_value_q;
  logic [RegIdxW-1:0] dest_index_q;
  logic               dest_written_q, illegal_q;

  logic               in_xfer, advance, do_wr;
  logic [RegIdxW-1:0] rs1_in, rs2_in, rs1, rs2;
  logic [XLen-1:0]    op_a, op_b_reg;
  exec_res_t          res;

  assign advance    = ex_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !ex_vld_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign rs1_in = instr_word_i[18:14];
  assign rs2_in = instr_word_i[4:0];
  assign rs1    = instr_q[18:14];
  assign rs2    = instr_q[4:0];

  // writes to r0 are dropped; illegal words leave state alone
  assign do_wr = advance && !res.illegal && res.wr && (res.widx != '0);

  sise_ram #(
    .Width (XLen),
    .Depth (NumRegs)
  ) u_gpr (
    .clk_i     (clk_i),
    .we_i      (do_wr),
    .waddr_i   (res.widx),
    .wdata_i   (res.wval),
    .re_i      (in_xfer),
    .raddr_a_i (rs1_in),
    .raddr_b_i (rs2_in),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // operand select: forwarded write, else RAM if ever written, else zero
  always_comb begin
    if (fwd_vld_q && fwd_idx_q == rs1) begin
      op_a = fwd_val_q;
    end else if (vld_a_q) begin
      op_a = rdata_a;
    end else begin
      op_a = '0;
    end
    if (fwd_vld_q && fwd_idx_q == rs2) begin
      op_b_reg = fwd_val_q;
    end else if (vld_b_q) begin
      op_b_reg = rdata_b;
    end else begin
      op_b_reg = '0;
    end
  end

  sise_alu u_alu (
    .instr_i    (instr_q),
    .op_a_i     (op_a),
    .op_b_reg_i (op_b_reg),
    .pc_i       (pc_q),
    .npc_i      (npc_q),
    .narrow_i   (narrow_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      narrow_q <= 1'b0;
    end else if (cfg_we_i && cfg_index_i == CfgNarrowMode) begin
      narrow_q <= cfg_wdata_i[0];
    end
  end

  // execute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      ex_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      instr_q <= instr_word_i;
      vld_a_q <= rvld_q[rs1_in];
      vld_b_q <= rvld_q[rs2_in];
    end
  end

  // pc/npc and register file bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= StartAddrReset;
      npc_q     <= StartAddrReset + PcStep;
      rvld_q    <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (advance && !res.illegal) begin
        pc_q  <= npc_q;
        npc_q <= res.npc_new;
      end
      if (do_wr) begin
        rvld_q[res.widx] <= 1'b1;
        fwd_vld_q        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      fwd_idx_q <= res.widx;
      fwd_val_q <= res.wval;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      exec_addr_q    <= pc_q;
      illegal_q      <= res.illegal;
      next_fetch_q   <= res.illegal ? pc_q : npc_q;
      dest_written_q <= do_wr;
      dest_index_q   <= do_wr ? res.widx : '0;
      dest_value_q   <= do_wr ? res.wval : '0;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign executed_address_o = exec_addr_q;
  assign next_fetch_o       = next_fetch_q;
  assign dest_index_o       = dest_index_q;
  assign dest_value_o       = dest_value_q;
  assign dest_written_o     = dest_written_q;
  assign illegal_o          = illegal_q;

endmodule

// ===== rtl/sise_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Depends on sise_pkg for the default sizes.
module sise_ram
  import sise_pkg::*;
#(
  parameter int unsigned Width = XLen,
  parameter int unsigned Depth = NumRegs
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a shared address
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== rtl/sise_alu.sv =====
// Instruction decode and execute: ALU, shifter and branch target logic.
// Depends on sise_pkg for opcode codes and the result struct.
module sise_alu
  import sise_pkg::*;
(
  input  logic [InstrW-1:0] instr_i,
  input  logic [XLen-1:0]   op_a_i,
  input  logic [XLen-1:0]   op_b_reg_i,
  input  logic [XLen-1:0]   pc_i,
  input  logic [XLen-1:0]   npc_i,
  input  logic              narrow_i,
  output exec_res_t         res_o
);

  logic [1:0]         op;
  logic [2:0]         op2;
  logic [5:0]         op3;
  logic [RegIdxW-1:0] rd;
  logic               xform;
  logic [XLen-1:0]    simm;
  logic [XLen-1:0]    op_b;
  logic [5:0]         cnt;
  logic [XLen-1:0]    lo_sext;
  logic [XLen-1:0]    sll_res;
  logic [XLen-1:0]    srl_res;
  logic [XLen-1:0]    sra_res;

  assign op    = instr_i[31:30];
  assign op2   = instr_i[24:22];
  assign op3   = instr_i[24:19];
  assign rd    = instr_i[29:25];
  assign xform = instr_i[12];
  assign simm  = {{(XLen-13){instr_i[12]}}, instr_i[12:0]};
  assign op_b  = instr_i[13] ? simm : op_b_reg_i;

  // 32-bit forms take a 5-bit count
  assign cnt     = xform ? op_b[5:0] : {1'b0, op_b[4:0]};
  assign lo_sext = {{(XLen-32){op_a_i[31]}}, op_a_i[31:0]};
  assign sll_res = op_a_i << cnt;
  assign srl_res = xform ? (op_a_i >> cnt) : ({{(XLen-32){1'b0}}, op_a_i[31:0]} >> cnt);
  assign sra_res = xform ? XLen'($signed(op_a_i) >>> cnt) : XLen'($signed(lo_sext) >>> cnt);

  always_comb begin
    res_o         = '0;
    res_o.npc_new = npc_i + PcStep;
    unique case (op)
      OpFmt2: begin
        if (op2 == Op2Bicc && rd == BranchAlways) begin
          res_o.npc_new = pc_i + {{(XLen-24){instr_i[21]}}, instr_i[21:0], 2'b00};
        end else if (op2 == Op2Sethi) begin
          res_o.wr   = 1'b1;
          res_o.widx = rd;
          res_o.wval = {{(XLen-32){1'b0}}, instr_i[21:0], 10'd0};
        end else begin
          res_o.illegal = 1'b1;
        end
      end
      OpCall: begin
        res_o.wr      = 1'b1;
        res_o.widx    = LinkReg;
        res_o.wval    = pc_i;
        res_o.npc_new = pc_i + {{(XLen-32){instr_i[29]}}, instr_i[29:0], 2'b00};
      end
      OpArith: begin
        res_o.wr   = 1'b1;
        res_o.widx = rd;
        unique case (op3)
          Op3Add:  res_o.wval = op_a_i + op_b;
          Op3And:  res_o.wval = op_a_i & op_b;
          Op3Or:   res_o.wval = op_a_i | op_b;
          Op3Xor:  res_o.wval = op_a_i ^ op_b;
          Op3Sub:  res_o.wval = op_a_i - op_b;
          Op3Sll:  res_o.wval = sll_res;
          Op3Srl:  res_o.wval = srl_res;
          Op3Sra:  res_o.wval = sra_res;
          Op3Jmpl: begin
            res_o.wval    = pc_i;
            res_o.npc_new = op_a_i + op_b;
          end
          default: res_o.illegal = 1'b1;
        endcase
        // x shifts do not exist on a 32-bit cpu
        if ((op3 == Op3Sll || op3 == Op3Srl || op3 == Op3Sra) && xform && narrow_i) begin
          res_o.illegal = 1'b1;
        end
      end
      default: res_o.illegal = 1'b1;
    endcase
  end

endmodule
